// ----- rtl/core/sm4_pkg.sv -----
// sm4 package: s-box table, fk/ck constants, round and key transforms,
// register indexes and the controller state type
// no dependencies
`timescale 1ns / 1ps

package sm4_pkg;

  // block and key geometry
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned RK_AW     = 5;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);

  // system parameters fk
  localparam logic [WORD_W-1:0] FK_0 = 32'ha3b1bac6;
  localparam logic [WORD_W-1:0] FK_1 = 32'h56aa3350;
  localparam logic [WORD_W-1:0] FK_2 = 32'h677d9197;
  localparam logic [WORD_W-1:0] FK_3 = 32'hb27022dc;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_LOAD,
    ST_KEY_EXP,
    ST_RUN,
    ST_DRAIN
  } state_t;

  localparam logic [7:0] SBOX_TAB [0:255] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // four parallel s-box lookups
  function automatic logic [WORD_W-1:0] sub_bytes(input logic [WORD_W-1:0] v);
    return {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]], SBOX_TAB[v[15:8]], SBOX_TAB[v[7:0]]};
  endfunction

  // data path transform t: s-box then l
  function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] b;
    b = sub_bytes(v);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction

  // key schedule transform t': s-box then l'
  function automatic logic [WORD_W-1:0] key_mix(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] b;
    b = sub_bytes(v);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // ck word for round i: byte j is (4i+j)*7 mod 256, msb first
  function automatic logic [WORD_W-1:0] ck_const(input logic [RK_AW-1:0] i);
    logic [WORD_W-1:0] r;
    logic [7:0]        idx;
    logic [7:0]        prod;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      idx  = {1'b0, i, 2'(j)};
      prod = 8'((idx << 3) - idx);
      r    = {r[23:0], prod};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sm4_ram.sv -----
// sm4 generic ram: one write port, one read port with registered read data
// no dependencies
`timescale 1ns / 1ps

module sm4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/sm4_block_cipher.sv -----
// sm4 block cipher top level: key registers, key schedule, round datapath
// depends on sm4_pkg and sm4_ram
`timescale 1ns / 1ps

// SM4 128-bit block cipher. Write the key through the four key registers
// (index 0 is the most significant word); every key write starts a fresh
// round key expansion (one load step plus the key rounds), during which no
// block is taken. The 32 round keys live in a 32x32 ram with a registered
// read; the first round key is read at the accepting edge and the datapath
// then runs one round per cycle, and when the output register is free the
// next block can be taken in the cycle right after the last round. A
// finished result sits in an output register; if it is still stalled when
// the next block finishes, that block waits in a drain state until the
// register frees. Set decrypt to apply the round keys in reverse order.
// Encrypting before any key write gives undefined results.
module sm4_block_cipher
  import sm4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  // input beat
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 decrypt,
  input  logic [WORD_W-1:0]    in_word_0,
  input  logic [WORD_W-1:0]    in_word_1,
  input  logic [WORD_W-1:0]    in_word_2,
  input  logic [WORD_W-1:0]    in_word_3,
  // output beat
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_word_0,
  output logic [WORD_W-1:0]    out_word_1,
  output logic [WORD_W-1:0]    out_word_2,
  output logic [WORD_W-1:0]    out_word_3
);

  state_t state;
  state_t state_next;

  logic [RK_AW-1:0]  cnt;
  logic              dec_mode;
  logic [WORD_W-1:0] key_0, key_1, key_2, key_3;
  logic [WORD_W-1:0] x0, x1, x2, x3;
  logic [WORD_W-1:0] k0, k1, k2, k3;

  logic              key_wr;
  logic              accept;
  logic              last;
  logic              out_free;
  logic              out_load;
  logic [RK_AW-1:0]  rd_addr;
  logic [WORD_W-1:0] rk;
  logic [WORD_W-1:0] round_out;
  logic [WORD_W-1:0] nk;
  logic              rk_wr_en;

  // key register writes; indexes past the key words are ignored
  always_comb begin
    unique case (cfg_index)
      REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: key_wr = cfg_write_en;
      default: key_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_0 <= '0;
      key_1 <= '0;
      key_2 <= '0;
      key_3 <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_KEY_WORD_0: key_0 <= cfg_data;
        REG_KEY_WORD_1: key_1 <= cfg_data;
        REG_KEY_WORD_2: key_2 <= cfg_data;
        REG_KEY_WORD_3: key_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // round functions
  assign round_out = x0 ^ round_mix(x1 ^ x2 ^ x3 ^ rk);
  assign nk        = k0 ^ key_mix(k1 ^ k2 ^ k3 ^ ck_const(cnt));

  // control outputs
  always_comb begin
    in_stall = (state != ST_IDLE) || key_wr;
    accept   = in_valid && !in_stall;
    last     = (cnt == RK_AW'(ROUNDS - 1));
    out_free = !out_valid || !out_stall;
    out_load = ((state == ST_RUN) && last && out_free) || ((state == ST_DRAIN) && out_free);
    rk_wr_en = (state == ST_KEY_EXP);
    if (accept) begin
      rd_addr = {RK_AW{decrypt}};
    end else begin
      rd_addr = (cnt + RK_AW'(1)) ^ {RK_AW{dec_mode}};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    priority if (key_wr) begin
      state_next = ST_KEY_LOAD;
    end else begin
      unique case (state)
        ST_IDLE:     if (accept) state_next = ST_RUN;
        ST_KEY_LOAD: state_next = ST_KEY_EXP;
        ST_KEY_EXP:  if (last) state_next = ST_IDLE;
        ST_RUN: begin
          if (last) state_next = out_free ? ST_IDLE : ST_DRAIN;
        end
        ST_DRAIN:    if (out_free) state_next = ST_IDLE;
        default:     state_next = ST_IDLE;
      endcase
    end
  end

  // state and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_KEY_EXP || state == ST_RUN) && !key_wr) begin
        cnt <= cnt + RK_AW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // block state words
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_mode <= decrypt;
      x0 <= in_word_0;
      x1 <= in_word_1;
      x2 <= in_word_2;
      x3 <= in_word_3;
    end else if (state == ST_RUN) begin
      x0 <= x1;
      x1 <= x2;
      x2 <= x3;
      x3 <= round_out;
    end
  end

  // key schedule words
  always_ff @(posedge clk) begin
    if (state == ST_KEY_LOAD) begin
      k0 <= key_0 ^ FK_0;
      k1 <= key_1 ^ FK_1;
      k2 <= key_2 ^ FK_2;
      k3 <= key_3 ^ FK_3;
    end else if (state == ST_KEY_EXP) begin
      k0 <= k1;
      k1 <= k2;
      k2 <= k3;
      k3 <= nk;
    end
  end

  // round key store
  sm4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUNDS)
  ) u_rk_ram (
    .clk     (clk),
    .wr_en   (rk_wr_en),
    .wr_addr (cnt),
    .wr_data (nk),
    .rd_addr (rd_addr),
    .rd_data (rk)
  );

  // output register, words in reversed order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_RUN) begin
        out_word_0 <= round_out;
        out_word_1 <= x3;
        out_word_2 <= x2;
        out_word_3 <= x1;
      end else begin
        out_word_0 <= x3;
        out_word_1 <= x2;
        out_word_2 <= x1;
        out_word_3 <= x0;
      end
    end
  end

endmodule
